/* src/bsst_pkg.sv */
package bsst_pkg;

  // Number of cells in the sorting chain, one stored value per cell.
  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W     = 11;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Flipping the sign bit makes unsigned order match signed order.
  localparam logic [VAL_W-1:0] SIGN_BIAS = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_TOO_FEW = 2'd2
  } status_e;

  // Token walking down the chain, one cell per cycle while the chain advances.
  //   live    : an insertion still carries a value that needs a cell
  //   settled : the new value has found its slot; key now holds a displaced value
  //   aux     : predecessor before settling, gap candidate after
  //   rem     : occupied cells still ahead of the token
  typedef struct packed {
    logic             valid;
    logic             ins;
    logic             live;
    logic             settled;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] aux;
    logic             aux_ok;
    logic [CNT_W-1:0] rem;
    logic [VAL_W-1:0] longest;
  } token_t;

endpackage

/* src/bsst_value_if.sv */
interface bsst_value_if;
  import bsst_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

/* src/bsst_cfg_if.sv */
interface bsst_cfg_if;
  import bsst_pkg::*;

  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/bsst_result_if.sv */
interface bsst_result_if;
  import bsst_pkg::*;

  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [CNT_OUT_W-1:0] stored_count;
  logic [31:0]          shortest_span;
  logic [31:0]          longest_span;

  modport source (output valid, output status, output stored_count,
                  output shortest_span, output longest_span, input ready);
  modport sink (input valid, input status, input stored_count,
                input shortest_span, input longest_span, output ready);
endinterface

/* src/bsst_cell.sv */
module bsst_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  bsst_pkg::token_t tok_i,
  output bsst_pkg::token_t tok_o
);
  import bsst_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;
  token_t           tok_q, tok_d;
  logic             valid_q;
  logic             occ;
  logic             le;
  logic [VAL_W-1:0] gap_lo, gap_hi, gap_pre, gap_min;

  always_comb begin
    tok_d   = tok_i;
    val_d   = val_q;
    occ     = (tok_i.rem != '0);
    le      = (val_q <= tok_i.key);
    gap_lo  = tok_i.key - tok_i.aux;
    gap_hi  = val_q - tok_i.key;
    gap_pre = tok_i.aux_ok ? gap_lo : '1;
    gap_min = (gap_hi < gap_pre) ? gap_hi : gap_pre;

    if (occ) begin
      tok_d.rem = tok_i.rem - CNT_W'(1);
    end

    if (tok_i.valid && tok_i.live) begin
      if (!tok_i.settled) begin
        if (occ && le) begin
          // equal values go after the held one
          tok_d.aux    = val_q;
          tok_d.aux_ok = 1'b1;
        end else if (occ) begin
          val_d         = tok_i.key;
          tok_d.key     = val_q;
          tok_d.settled = 1'b1;
          tok_d.aux     = gap_min;
          tok_d.aux_ok  = 1'b1;
        end else begin
          // first empty cell: new value lands at the top end
          val_d         = tok_i.key;
          tok_d.live    = 1'b0;
          tok_d.settled = 1'b1;
          tok_d.aux     = gap_pre;
          tok_d.aux_ok  = tok_i.aux_ok;
        end
      end else if (occ) begin
        val_d     = tok_i.key;
        tok_d.key = val_q;
      end else begin
        val_d      = tok_i.key;
        tok_d.live = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q <= val_d;
      tok_q <= tok_d;
    end
  end

  // valid comes from the reset flop, the rest from the payload register
  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

/* src/bsst_chain.sv */
module bsst_chain (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  bsst_pkg::token_t tok_i,
  output bsst_pkg::token_t tok_o
);
  import bsst_pkg::*;

  token_t link [DEPTH+1];

  assign link[0] = tok_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bsst_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv_i),
      .tok_i (link[i]),
      .tok_o (link[i+1])
    );
  end

  assign tok_o = link[DEPTH];

endmodule

/* src/bounded_set_span_tracker_core.sv */
// Sorted-set span tracker. Each accepted transaction carries one signed 32-bit
// value; the block answers every transaction with exactly one result: status
// (ok, full, or fewer than two values), the count held afterwards, the least
// gap between sorted neighbors and the max-minus-min range, both as exact
// unsigned differences (zero while fewer than two values are held). Values
// live in a chain of DEPTH cells kept in ascending order; a token enters the
// head of the chain, walks one cell per cycle, drops the new value into its
// slot and pushes the larger values one cell up. A new transaction can enter
// every cycle, so throughput is one value per clock unless the output stalls;
// each result passes through every cell register and then the output register.
// A stalled result holds the whole chain and the input side. Full and range
// are decided at the chain head; the least gap is folded in at the chain tail.
// The capacity register is written through its own channel, always ready; the
// user writes it only while the block is idle, which the block does not enforce;
// capacities above DEPTH act as DEPTH and lowering it never drops values.
module bounded_set_span_tracker_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsst_value_if.sink   in_if,
  bsst_cfg_if.sink     cfg_if,
  bsst_result_if.source out_if
);
  import bsst_pkg::*;

  // configuration
  logic [CAP_W-1:0] cap_q;

  // chain head bookkeeping (counts every value admitted, in flight or not)
  logic [CNT_W-1:0] count_q, count_d;
  logic [VAL_W-1:0] min_q, min_d, max_q, max_d;

  // chain tail bookkeeping
  logic [CNT_W-1:0] ex_cnt_q, ex_cnt_d;
  logic [VAL_W-1:0] least_q, least_d;

  // output register
  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [CNT_OUT_W-1:0] stored_q;
  logic [VAL_W-1:0]     short_q, short_d;
  logic [VAL_W-1:0]     long_q;

  logic             adv;
  logic             accept;
  logic             full;
  logic [CMP_W-1:0] cap_ext, depth_ext, eff_cap;
  logic [VAL_W-1:0] key;
  logic [CNT_W-1:0] cnt_after;
  logic [VAL_W-1:0] new_min, new_max;
  token_t           head_tok, tail_tok;

  // The whole pipeline moves when the output register is free or being emptied.
  assign adv          = !out_valid_q || out_if.ready;
  assign in_if.ready  = adv;
  assign cfg_if.ready = 1'b1;
  assign accept       = in_if.valid && adv;

  // ---- chain head ----
  always_comb begin
    cap_ext   = CMP_W'(cap_q);
    depth_ext = CMP_W'(DEPTH);
    eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    full      = (CMP_W'(count_q) >= eff_cap);
    key       = in_if.value ^ SIGN_BIAS;
    cnt_after = count_q + CNT_W'(1);
    new_min   = (count_q == '0 || key < min_q) ? key : min_q;
    new_max   = (count_q == '0 || key > max_q) ? key : max_q;

    count_d = count_q;
    min_d   = min_q;
    max_d   = max_q;
    if (accept && !full) begin
      count_d = cnt_after;
      min_d   = new_min;
      max_d   = new_max;
    end

    head_tok          = '0;
    head_tok.valid    = accept;
    head_tok.ins      = !full;
    head_tok.live     = !full;
    head_tok.settled  = 1'b0;
    head_tok.key      = key;
    head_tok.aux      = '0;
    head_tok.aux_ok   = 1'b0;
    head_tok.rem      = count_q;
    if (!full) begin
      head_tok.longest = (cnt_after >= CNT_W'(2)) ? (new_max - new_min) : '0;
    end else begin
      // rejected: range of the unchanged set
      head_tok.longest = (count_q >= CNT_W'(2)) ? (max_q - min_q) : '0;
    end
  end

  bsst_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .tok_i (head_tok),
    .tok_o (tail_tok)
  );

  // ---- chain tail ----
  always_comb begin
    ex_cnt_d = ex_cnt_q;
    least_d  = least_q;
    if (tail_tok.valid && tail_tok.ins) begin
      ex_cnt_d = ex_cnt_q + CNT_W'(1);
      if (tail_tok.aux_ok && tail_tok.aux < least_q) begin
        least_d = tail_tok.aux;
      end
    end

    short_d = (ex_cnt_d >= CNT_W'(2)) ? least_d : '0;

    if (!tail_tok.ins) begin
      status_d = STATUS_FULL;
    end else if (ex_cnt_d < CNT_W'(2)) begin
      status_d = STATUS_TOO_FEW;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= '0;
      count_q     <= '0;
      ex_cnt_q    <= '0;
      least_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        cap_q <= cfg_if.data;
      end
      if (adv) begin
        count_q     <= count_d;
        out_valid_q <= tail_tok.valid;
        if (tail_tok.valid) begin
          ex_cnt_q <= ex_cnt_d;
          least_q  <= least_d;
        end
      end
    end
  end

  // Range tracking and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      min_q <= min_d;
      max_q <= max_d;
      if (tail_tok.valid) begin
        status_q <= status_d;
        stored_q <= CNT_OUT_W'(ex_cnt_d);
        short_q  <= short_d;
        long_q   <= tail_tok.longest;
      end
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = status_q;
  assign out_if.stored_count  = stored_q;
  assign out_if.shortest_span = short_q;
  assign out_if.longest_span  = long_q;

  // ---- assertions ----

  // Values leaving the chain never outnumber those admitted, nor the cells.
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ex_cnt_q <= count_q) && (count_q <= CNT_W'(DEPTH)))
    else $error("tail count ahead of head count or above depth");

  // Every inserted value has found a cell by the time its token leaves.
  a_value_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_tok.valid && tail_tok.ins) |-> !tail_tok.live)
    else $error("inserted value fell off the end of the chain");

  // An ok result always reports at least two values.
  a_ok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STATUS_OK) |-> (stored_q >= CNT_OUT_W'(2)))
    else $error("ok status with fewer than two values");

  // A rejected transaction never moves the head count.
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full) |=> (count_q == $past(count_q)))
    else $error("rejected value changed the count");

endmodule

/* verif/bounded_set_span_tracker_core_tb.sv */
`timescale 1ns / 1ps

module bounded_set_span_tracker_core_tb;
  import bsst_pkg::*;

  // No handshake of any kind for this many cycles means the block is hung.
  // This limit is well above the time a result takes to cross the cell chain.
  localparam int unsigned HANG_LIMIT = 20000;

  typedef struct packed {
    status_e              status;
    logic [CNT_OUT_W-1:0] count;
    logic [VAL_W-1:0]     shortest;
    logic [VAL_W-1:0]     longest;
  } span_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bsst_value_if  value_ch ();
  bsst_cfg_if    cfg_ch ();
  bsst_result_if result_ch ();

  bounded_set_span_tracker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (value_ch),
    .cfg_if (cfg_ch),
    .out_if (result_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the sorted set. Keys are stored sign-flipped so plain
  // unsigned compares give signed order and differences are exact spans.
  logic [VAL_W-1:0] shadow_keys [DEPTH];
  int unsigned      shadow_count    = 0;
  logic [VAL_W-1:0] shadow_gap      = '1;
  logic [CAP_W-1:0] shadow_capacity = '0;

  logic [VAL_W-1:0] pending_values [$];
  logic [VAL_W-1:0] value_history [$];
  span_report_t     expected_reports [$];

  int unsigned values_queued   = 0;
  int unsigned values_accepted = 0;
  int unsigned reports_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned capacity_writes = 0;
  int unsigned ok_seen         = 0;
  int unsigned full_seen       = 0;
  int unsigned few_seen        = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned source_gap_pct;
  int unsigned sink_stall_pct;

  // Backpressure profile: light source gaps with a heavily stalled sink, then
  // the reverse, then full rate on both sides.
  always_comb begin
    if (values_accepted < 550) begin
      source_gap_pct = 9;
      sink_stall_pct = 76;
    end else if (values_accepted < 1100) begin
      source_gap_pct = 76;
      sink_stall_pct = 9;
    end else begin
      source_gap_pct = 0;
      sink_stall_pct = 0;
    end
  end

  // Inserts one value into the shadow set and returns the report the block
  // owes for it. A full set drops the value and reports on what is held.
  function automatic span_report_t insert_and_measure(logic [VAL_W-1:0] value);
    span_report_t     rpt;
    logic [VAL_W-1:0] key;
    logic [VAL_W-1:0] gap;
    int unsigned      limit;
    int unsigned      slot;
    int unsigned      i;
    key   = value ^ SIGN_BIAS;
    limit = (shadow_capacity < DEPTH) ? shadow_capacity : DEPTH;
    if (shadow_count >= limit) begin
      rpt.status = STATUS_FULL;
    end else begin
      // Slot goes after any equal keys, so duplicates are kept.
      slot = 0;
      while (slot < shadow_count && shadow_keys[slot] <= key) slot++;
      if (slot > 0) begin
        gap = key - shadow_keys[slot-1];
        if (gap < shadow_gap) shadow_gap = gap;
      end
      if (slot < shadow_count) begin
        gap = shadow_keys[slot] - key;
        if (gap < shadow_gap) shadow_gap = gap;
      end
      for (i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
      shadow_keys[slot] = key;
      shadow_count++;
      rpt.status = (shadow_count < 2) ? STATUS_TOO_FEW : STATUS_OK;
    end
    rpt.count = CNT_OUT_W'(shadow_count);
    if (shadow_count >= 2) begin
      rpt.shortest = shadow_gap;
      rpt.longest  = shadow_keys[shadow_count-1] - shadow_keys[0];
    end else begin
      rpt.shortest = '0;
      rpt.longest  = '0;
    end
    return rpt;
  endfunction

  function automatic void check_field(string field, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // Random value. Without close_ok only wide values, so the least gap stays
  // non-zero and keeps moving. With it, neighbors of earlier values, exact
  // repeats and values hugging either end of the signed range.
  function automatic logic [VAL_W-1:0] next_value(bit close_ok);
    int unsigned      pick;
    logic [VAL_W-1:0] seen;
    pick = close_ok ? $urandom_range(0, 99) : 0;
    seen = value_history[$urandom_range(0, value_history.size() - 1)];
    if (pick < 55) return $urandom;
    else if (pick < 75) return seen + VAL_W'($urandom_range(0, 6)) - VAL_W'(3);
    else if (pick < 85) return seen;
    else if (pick < 93) return SIGN_BIAS + VAL_W'($urandom_range(0, 15));
    else return ~SIGN_BIAS - VAL_W'($urandom_range(0, 15));
  endfunction

  task automatic queue_value(logic [VAL_W-1:0] value);
    pending_values = {pending_values, value};
    value_history  = {value_history, value};
    values_queued++;
  endtask

  // Every value yields one result, so the block is idle once all are checked.
  task automatic settle();
    while (reports_checked < values_queued) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cap;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    shadow_capacity = cap;
    capacity_writes++;
  endtask

  // Driver: keeps a value on the channel until it is taken, then pulls the
  // next one from the pending queue unless this cycle is a source gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      value_ch.valid <= 1'b0;
    end else begin
      if (value_ch.valid && value_ch.ready) begin
        expected_reports = {expected_reports, insert_and_measure(value_ch.value)};
        values_accepted++;
      end
      if (!value_ch.valid || value_ch.ready) begin
        if (pending_values.size() != 0 && $urandom_range(0, 99) >= source_gap_pct) begin
          value_ch.valid <= 1'b1;
          value_ch.value <= pending_values.pop_front();
        end else begin
          value_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random sink stalls, in-order compare against the oldest report,
  // and a hang watchdog.
  always @(posedge clk_i) begin : result_monitor
    span_report_t want;
    if (!rst_ni) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      if (result_ch.valid && result_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                   $time, result_ch.status, result_ch.stored_count);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", VAL_W'(want.status), VAL_W'(result_ch.status));
          check_field("stored_count", VAL_W'(want.count), VAL_W'(result_ch.stored_count));
          check_field("shortest_span", want.shortest, result_ch.shortest_span);
          check_field("longest_span", want.longest, result_ch.longest_span);
        end
        case (result_ch.status)
          STATUS_OK:      ok_seen++;
          STATUS_FULL:    full_seen++;
          STATUS_TOO_FEW: few_seen++;
          default:        ;
        endcase
        reports_checked++;
      end
      if ((value_ch.valid && value_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
          $display("bounded_set_span_tracker_core_tb: done, errors");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    value_ch.valid  = 1'b0;
    value_ch.value  = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = '0;
    result_ch.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Capacity still zero from reset: everything bounces, spans read zero.
    queue_value(32'h8000_0000);
    queue_value(32'h7fff_ffff);

    // Capacity 1: first value gives too-few, the next bounces with one held.
    write_capacity(11'd1);
    queue_value(32'h0000_0000);
    queue_value(32'hffff_ffff);

    // Lowered below the count: rejects, keeps what is held.
    write_capacity(11'd0);
    queue_value(32'h0000_0007);

    // Both ends of the signed range: longest span is all ones.
    write_capacity(11'd3);
    queue_value(32'h8000_0000);
    queue_value(32'h7fff_ffff);
    queue_value(32'h0000_0001);

    // Wide random values; set fills at 100 and the rest bounce.
    write_capacity(11'd100);
    repeat (200) queue_value(next_value(1'b0));

    // Capacity above DEPTH acts as DEPTH. Wide values first, then repeats of
    // both extremes to drive the least gap to zero, then clustered values
    // until the chain is full.
    write_capacity(11'h7ff);
    repeat (650) queue_value(next_value(1'b0));
    queue_value(32'h8000_0000);
    queue_value(32'h7fff_ffff);
    repeat (750) queue_value(next_value(1'b1));

    // Full chain under a small capacity and under exactly DEPTH.
    write_capacity(11'd2);
    repeat (25) queue_value(next_value(1'b1));
    write_capacity(11'd1024);
    repeat (25) queue_value(next_value(1'b1));

    settle();
    // Anything the block emits past this point is flagged by the monitor.
    repeat (DEPTH + 8) @(posedge clk_i);

    $display("checked %0d results after %0d capacity writes: %0d ok, %0d full, %0d too few",
             reports_checked, capacity_writes, ok_seen, full_seen, few_seen);
    $display("set ended with %0d values, least gap %0h", shadow_count, shadow_gap);
    if (mismatch_count == 0) begin
      $display("bounded_set_span_tracker_core_tb: done, clean");
    end else begin
      $display("bounded_set_span_tracker_core_tb: done, errors");
    end
    $finish;
  end

endmodule
